>>> rtl/core/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block allocator package
// Shared constants, status codes and request/response payload types for the
// first-fit bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	// Default sizing of the bitmap. The word width must be a power of two.
	localparam int unsigned MAX_BLOCKS_DEF    = 4096;
	localparam int unsigned MAP_WORD_BITS_DEF = 64;

	// Fixed field widths of the interface.
	localparam int unsigned DISK_BLOCKS_W = 13;
	localparam int unsigned BLOCK_W       = 12;

	localparam logic [DISK_BLOCKS_W-1:0] DISK_BLOCKS_RESET = 13'd4096;

	// Request kinds.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_FULL        = 2'd1,
		STATUS_DOUBLE_FREE = 2'd2,
		STATUS_RANGE       = 2'd3
	} status_t;

	typedef struct packed {
		logic               req_type;
		logic [BLOCK_W-1:0] block_number;
	} req_t;

	typedef struct packed {
		logic [BLOCK_W-1:0] granted_block;
		status_t            status;
	} rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/bitmap_block_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit bitmap block allocator
// Keeps one in-use bit per disk block in a synchronous bitmap memory. An
// allocate request scans the bitmap for the lowest free block below the disk
// size and marks it used; a free request clears the bit of one block.
// ----------------------------------------------------------------------------
// Sequence: an allocate reads and scans the bitmap word by word from word 0, a free reads one
// word and writes it back, and a request rejected at once goes straight to the done state. A
// new request is taken only after the last result has moved to the response register. The
// single read port scans one word per cycle, and a full response register holds a finished
// result. Reset: arst_n clears the registers, then a pass zeroes every bitmap word (64 by
// default) before requests are taken; disk size resets to 4096.
module bitmap_block_allocator_unit
	import bba_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS    = MAX_BLOCKS_DEF,
	parameter int unsigned MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// Request channel.
	input  wire logic                     req_valid,
	output logic                          req_ready,
	input  wire req_t                     req_data,
	// Response channel.
	output logic                          rsp_valid,
	input  wire logic                     rsp_ready,
	output rsp_t                          rsp_data,
	// Disk size register.
	input  wire logic                     disk_blocks_we,
	input  wire logic [DISK_BLOCKS_W-1:0] disk_blocks_wdata
);

	// Number of bitmap words and the widths derived from it.
	localparam int unsigned MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned WBL       = $clog2(MAP_WORD_BITS);
	localparam int unsigned BNW       = AW + WBL;
	// The size arithmetic must hold both the register value and MAX_BLOCKS.
	localparam int unsigned SW_MAX    = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned SW        = (SW_MAX > DISK_BLOCKS_W) ? SW_MAX : DISK_BLOCKS_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FREE,
		ST_DONE
	} state_t;

	typedef logic [MAP_WORD_BITS-1:0] map_word_t;

	// Bitmap memory: one read port and one write port, read data registered.
	map_word_t mem [MAP_WORDS];

	state_t                   state_q;
	logic [DISK_BLOCKS_W-1:0] disk_blocks_q;
	logic [AW-1:0]            clr_addr_q;
	logic [AW-1:0]            word_s1;
	logic [SW-1:0]            rem_s1;
	logic [WBL-1:0]           free_bit_q;
	map_word_t                rd_data_s1;
	rsp_t                     res_q;
	rsp_t                     rsp_q;
	logic                     rsp_valid_q;

	logic          accept;
	logic [SW-1:0] size_w;
	logic          in_range;
	logic [AW-1:0] req_word;
	map_word_t     scan_mask;
	map_word_t     avail;
	logic          found;
	logic [WBL-1:0] found_idx;
	logic          last_word;
	logic [BNW-1:0] grant_full;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	map_word_t     wr_data;

	// The disk size saturates at the number of blocks the bitmap covers.
	always_comb begin
		if (SW'(disk_blocks_q) > SW'(MAX_BLOCKS)) begin
			size_w = SW'(MAX_BLOCKS);
		end else begin
			size_w = SW'(disk_blocks_q);
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign in_range  = SW'(req_data.block_number) < size_w;
	assign req_word  = AW'(req_data.block_number >> WBL);

	// rem_s1 counts the blocks left from the start of the word in the read
	// data register; only bits below it take part in the scan.
	always_comb begin
		for (int b = 0; b < MAP_WORD_BITS; b++) begin
			scan_mask[b] = rem_s1 > SW'(b);
		end
	end

	assign avail     = ~rd_data_s1 & scan_mask;
	assign found     = |avail;
	assign last_word = rem_s1 <= SW'(MAP_WORD_BITS);

	// Lowest free bit of the current word.
	always_comb begin
		found_idx = '0;
		for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
			if (avail[b]) begin
				found_idx = WBL'(b);
			end
		end
	end

	assign grant_full = {word_s1, found_idx};

	// Memory port control. The scan reads the next word while it examines the
	// current one, so the scan moves one word per cycle. The word written when
	// a block is found is never the one being read in the same cycle.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = word_s1;
		wr_data = '0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
			end
			ST_IDLE: begin
				if (accept) begin
					if (req_data.req_type == REQ_ALLOC) begin
						rd_en   = (size_w != '0);
						rd_addr = '0;
					end else begin
						rd_en   = in_range;
						rd_addr = req_word;
					end
				end
			end
			ST_SCAN: begin
				if (found) begin
					wr_en   = 1'b1;
					wr_data = rd_data_s1 | (map_word_t'(1) << found_idx);
				end else if (!last_word) begin
					rd_en   = 1'b1;
					rd_addr = word_s1 + AW'(1);
				end
			end
			ST_FREE: begin
				wr_en   = 1'b1;
				wr_data = rd_data_s1 & ~(map_word_t'(1) << free_bit_q);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// The disk size register must be written only while idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_blocks_q <= DISK_BLOCKS_RESET;
		end else if (disk_blocks_we) begin
			disk_blocks_q <= disk_blocks_wdata;
		end
	end

	// Sequencer. A finished result waits in res_q until the response register
	// is free; new requests are taken while an older response is unclaimed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			word_s1     <= '0;
			rem_s1      <= '0;
			free_bit_q  <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// In the done state the handoff below owns the response valid.
			if (rsp_valid_q && rsp_ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(MAP_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_q.granted_block <= '0;
						if (req_data.req_type == REQ_ALLOC) begin
							word_s1 <= '0;
							rem_s1  <= size_w;
							if (size_w == '0) begin
								res_q.status <= STATUS_FULL;
								state_q      <= ST_DONE;
							end else begin
								state_q <= ST_SCAN;
							end
						end else begin
							word_s1    <= req_word;
							free_bit_q <= req_data.block_number[WBL-1:0];
							if (!in_range) begin
								res_q.status <= STATUS_RANGE;
								state_q      <= ST_DONE;
							end else begin
								state_q <= ST_FREE;
							end
						end
					end
				end
				ST_SCAN: begin
					if (found) begin
						res_q.granted_block <= BLOCK_W'(grant_full);
						res_q.status        <= STATUS_OK;
						state_q             <= ST_DONE;
					end else if (last_word) begin
						res_q.granted_block <= '0;
						res_q.status        <= STATUS_FULL;
						state_q             <= ST_DONE;
					end else begin
						word_s1 <= word_s1 + AW'(1);
						rem_s1  <= rem_s1 - SW'(MAP_WORD_BITS);
					end
				end
				ST_FREE: begin
					res_q.granted_block <= '0;
					if (rd_data_s1[free_bit_q]) begin
						res_q.status <= STATUS_OK;
					end else begin
						res_q.status <= STATUS_DOUBLE_FREE;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef NO_ASSERTIONS
	// The write-back never targets the word being read in the same cycle.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("bitmap read and write hit the same word");

	// The scan always has at least one block left in the word it examines.
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rem_s1 != '0))
		else $error("scan running past the disk size");

	// A finished result moves to the response register as soon as it is free.
	a_done_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!rsp_valid_q || rsp_ready))
		|=> (rsp_valid_q && state_q == ST_IDLE))
		else $error("finished result not handed to the response register");

	// An accepted request always leaves the idle state.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted request was dropped");
`endif

endmodule
`default_nettype wire
